// File: hw/rtl/dmg_pkg.sv
// Shared constants and types for the depth min/max to gray normalizer.
// No dependencies; imported by depth_min_max_to_gray and its testbench.
package dmg_pkg;

   // Width of the depth sample that takes part in the arithmetic.
   localparam int SAMPLE_BITS = 16;
   // Width of the depth field on the input stream.
   localparam int DEPTH_BITS  = 16;
   // Width of the gray result and its full-scale value.
   localparam int GRAY_BITS   = 8;
   localparam logic [GRAY_BITS-1:0] GRAY_MAX = 8'd255;
   // Width of the digit counter of the serial divider.
   localparam int CNT_BITS    = $clog2(GRAY_BITS);

   // Command codes carried in the low bit of req_tuser.
   localparam logic CMD_MEASURE = 1'b0;
   localparam logic CMD_CONVERT = 1'b1;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PREP  = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

endpackage

// File: hw/rtl/depth_min_max_to_gray.sv
// Top level of the depth min/max to gray normalizer: range tracking,
// a bit-serial restoring divider and the output register.
// Depends on dmg_pkg.

// Two-pass normalizer for 16-bit depth frames without a frame store. A
// measure beat (cmd 0) widens the running range in the cycle it is accepted,
// or restarts it when first is set, so measure beats flow at one per cycle
// while no convert beat is in progress. A convert beat (cmd 1) holds the
// input off until its result is written, so no new beat is taken before it
// is through: the prep state forms 255*(depth-min) and the range, the
// divide state runs the restoring divider one quotient bit per cycle for
// all eight quotient bits, and the write state moves the result into the
// output register. Samples outside the measured range, and a zero range,
// skip the divider and go from prep to write. The write state waits while
// the previous result is still held by the downstream side. A new beat is
// accepted while the previous result still waits in the output register.
module depth_min_max_to_gray (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] depth
   input  logic [1:0]  req_tuser,    // [0] cmd, [1] first
   input  logic        req_tlast,    // last
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] gray
   output logic [0:0]  rsp_tuser,    // [0] clipped
   output logic        rsp_tlast     // end_of_frame
);
   import dmg_pkg::*;

   localparam int NUM_BITS = SAMPLE_BITS + GRAY_BITS;

   state_type                state_ff, state_in;
   logic [SAMPLE_BITS-1:0]   low_ff, low_in;
   logic [SAMPLE_BITS-1:0]   high_ff, high_in;
   logic [SAMPLE_BITS-1:0]   sample_ff, sample_in;
   logic                     last_ff, last_in;
   logic [SAMPLE_BITS-1:0]   divisor_ff, divisor_in;
   logic [SAMPLE_BITS-1:0]   rem_ff, rem_in;
   logic [GRAY_BITS-1:0]     num_ff, num_in;
   logic [GRAY_BITS-1:0]     quot_ff, quot_in;
   logic                     clip_ff, clip_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                     out_valid_ff, out_valid_in;
   logic [GRAY_BITS-1:0]     out_gray_ff, out_gray_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_clip_ff, out_clip_in;

   logic                     accept;
   logic [SAMPLE_BITS-1:0]   req_sample;
   logic [SAMPLE_BITS-1:0]   offset;
   logic [NUM_BITS-1:0]      scaled;
   logic [SAMPLE_BITS:0]     trial;
   logic                     trial_ge;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign req_sample = req_tdata[SAMPLE_BITS-1:0];

   // Offset from the minimum and 255 times it, as (x << 8) - x.
   assign offset = sample_ff - low_ff;
   assign scaled = {offset, {GRAY_BITS{1'b0}}} - {{GRAY_BITS{1'b0}}, offset};

   // One restoring step: bring down the next numerator bit and compare.
   assign trial    = {rem_ff, num_ff[GRAY_BITS-1]};
   assign trial_ge = (trial >= {1'b0, divisor_ff});

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      quot_in      = quot_ff;
      clip_in      = clip_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      out_gray_in  = out_gray_ff;
      out_last_in  = out_last_ff;
      out_clip_in  = out_clip_ff;

      // The downstream side takes the waiting result.
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser[0] == CMD_MEASURE) begin
                  // Measure beat: restart or widen the range.
                  if (req_tuser[1]) begin
                     low_in  = req_sample;
                     high_in = req_sample;
                  end else begin
                     if (req_sample < low_ff) begin
                        low_in = req_sample;
                     end
                     if (req_sample > high_ff) begin
                        high_in = req_sample;
                     end
                  end
               end else begin
                  sample_in = req_sample;
                  last_in   = req_tlast;
                  state_in  = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            cnt_in  = '0;
            clip_in = 1'b0;
            if (sample_ff < low_ff) begin
               // Below the range saturates to black.
               quot_in  = '0;
               clip_in  = 1'b1;
               state_in = ST_WRITE;
            end else if (sample_ff > high_ff) begin
               // Above the range saturates to white.
               quot_in  = GRAY_MAX;
               clip_in  = 1'b1;
               state_in = ST_WRITE;
            end else if (high_ff == low_ff) begin
               // A zero range maps its single value to black.
               quot_in  = '0;
               state_in = ST_WRITE;
            end else begin
               // The high part of the numerator is already below the divisor.
               divisor_in = high_ff - low_ff;
               rem_in     = scaled[NUM_BITS-1:GRAY_BITS];
               num_in     = scaled[GRAY_BITS-1:0];
               quot_in    = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            if (trial_ge) begin
               rem_in = trial[SAMPLE_BITS-1:0] - divisor_ff;
            end else begin
               rem_in = trial[SAMPLE_BITS-1:0];
            end
            num_in  = {num_ff[GRAY_BITS-2:0], 1'b0};
            quot_in = {quot_ff[GRAY_BITS-2:0], trial_ge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(GRAY_BITS - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // Load the output register once it is free.
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_gray_in  = quot_ff;
               out_last_in  = last_ff;
               out_clip_in  = clip_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and range registers take reset; payload registers do not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         low_ff       <= '0;
         high_ff      <= '0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      last_ff     <= last_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      quot_ff     <= quot_in;
      clip_ff     <= clip_in;
      out_gray_ff <= out_gray_in;
      out_last_ff <= out_last_in;
      out_clip_ff <= out_clip_in;
   end

   // Result stream outputs.
   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_gray_ff;
   assign rsp_tlast    = out_last_ff;
   assign rsp_tuser[0] = out_clip_ff;

endmodule

// File: tb/depth_min_max_to_gray_tb.sv
// Self-checking testbench for the depth min/max to gray normalizer.
// Predicts every gray beat in its own range tracker and compares the result stream.
// Depends on dmg_pkg and depth_min_max_to_gray.
`timescale 1ns / 1ps

module depth_min_max_to_gray_tb;
   import dmg_pkg::*;

   localparam int unsigned SAMPLE_MASK  = (1 << SAMPLE_BITS) - 1;
   localparam int unsigned RANDOM_ITEMS = 1950;
   localparam int unsigned PHASE_ITEMS  = 150;
   localparam int unsigned HOLD_AT      = 60;
   localparam int unsigned HOLD_CYCLES  = 400;

   // One input beat, and one result beat, as the block sees them.
   typedef struct {
      logic                  cmd;
      logic [DEPTH_BITS-1:0] depth;
      logic                  first;
      logic                  last;
   } depth_sample_type;

   typedef struct {
      logic [GRAY_BITS-1:0] gray;
      logic                 eof;
      logic                 clipped;
   } gray_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;    // [15:0] depth
   logic [1:0]  req_tuser  = '0;    // [0] cmd, [1] first
   logic        req_tlast  = 1'b0;  // last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [7:0] gray
   logic [0:0]  rsp_tuser;          // [0] clipped
   logic        rsp_tlast;          // end_of_frame

   depth_min_max_to_gray dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   depth_sample_type pending_samples[$];
   gray_result_type  gray_expected[$];
   depth_sample_type offered;
   gray_result_type  seen_gray;
   gray_result_type  want_gray;
   int unsigned      range_low;
   int unsigned      range_high;
   int unsigned      sent_count = 0;
   int unsigned      hold_left  = 0;
   logic             hold_done  = 1'b0;
   int unsigned      error_count = 0;

   function automatic bit chance(input int unsigned pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   // Idle mix rotates with the number of beats sent: none, sender, receiver, both.
   function automatic int unsigned sender_idle_pct(input int unsigned count);
      case ((count / PHASE_ITEMS) % 4)
         1: return 65;
         3: return 19;
         default: return 0;
      endcase
   endfunction

   function automatic int unsigned receiver_stall_pct(input int unsigned count);
      case ((count / PHASE_ITEMS) % 4)
         2: return 65;
         3: return 19;
         default: return 0;
      endcase
   endfunction

   // Tracks the measured range and queues the gray beat a convert sample yields.
   function automatic void predict_gray(input depth_sample_type s);
      int unsigned     d;
      gray_result_type r;
      d = int'(s.depth) & SAMPLE_MASK;
      if (s.cmd == CMD_MEASURE) begin
         if (s.first) begin
            range_low  = d;
            range_high = d;
         end else begin
            if (d < range_low) range_low = d;
            if (d > range_high) range_high = d;
         end
      end else begin
         r.eof     = s.last;
         r.clipped = 1'b0;
         if (d < range_low) begin
            r.gray    = '0;
            r.clipped = 1'b1;
         end else if (d > range_high) begin
            r.gray    = GRAY_MAX;
            r.clipped = 1'b1;
         end else if (range_high == range_low) begin
            // A flat range maps to black instead of dividing by zero.
            r.gray = '0;
         end else begin
            r.gray = GRAY_BITS'((int'(GRAY_MAX) * (d - range_low)) / (range_high - range_low));
         end
         gray_expected.push_back(r);
      end
   endfunction

   task automatic add_sample(input logic cmd, input int unsigned depth,
                             input logic first, input logic last);
      depth_sample_type s;
      s.cmd   = cmd;
      s.depth = DEPTH_BITS'(depth);
      s.first = first;
      s.last  = last;
      pending_samples.push_back(s);
   endtask

   // One random frame: mostly a measure pass and a convert pass, sometimes pure noise.
   task automatic add_random_frame();
      int unsigned base;
      int unsigned span;
      int unsigned top;
      int unsigned lo;
      int unsigned hi;
      int unsigned d;
      int unsigned n_measure;
      int unsigned n_convert;
      if (chance(15)) begin
         repeat ($urandom_range(8, 1))
            add_sample(1'($urandom_range(1, 0)), $urandom_range(65535, 0),
                       1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
      end else begin
         base = $urandom_range(65535, 0);
         case ($urandom_range(3, 0))
            0: span = 0;
            1: span = $urandom_range(16, 1);
            2: span = $urandom_range(4096, 17);
            default: begin
               span = 65535;
               if (chance(50)) base = 0;
            end
         endcase
         top = (base + span > 65535) ? 65535 : base + span;
         n_measure = $urandom_range(10, 1);
         n_convert = $urandom_range(12, 1);
         lo = 65535;
         hi = 0;
         for (int i = 0; i < n_measure; i++) begin
            d = $urandom_range(top, base);
            if (d < lo) lo = d;
            if (d > hi) hi = d;
            add_sample(CMD_MEASURE, d, i == 0, i == n_measure - 1);
         end
         for (int i = 0; i < n_convert; i++) begin
            d = chance(85) ? $urandom_range(hi, lo) : $urandom_range(65535, 0);
            add_sample(CMD_CONVERT, d, chance(5), i == n_convert - 1);
         end
      end
   endtask

   // Driver: offers the next pending sample once the previous beat is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_gray(offered);
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0 && !chance(sender_idle_pct(sent_count))) begin
               offered = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= offered.depth;
               req_tuser  <= {offered.first, offered.cmd};
               req_tlast  <= offered.last;
               sent_count <= sent_count + 1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off that backs up the input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !chance(receiver_stall_pct(sent_count));
      end
   end

   // Monitor: each gray beat must match the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_gray.gray    = rsp_tdata;
         seen_gray.eof     = rsp_tlast;
         seen_gray.clipped = rsp_tuser[0];
         if (gray_expected.size() == 0) begin
            $error("unexpected gray beat: gray=%0d end_of_frame=%0b clipped=%0b",
                   seen_gray.gray, seen_gray.eof, seen_gray.clipped);
            error_count++;
         end else begin
            want_gray = gray_expected.pop_front();
            if (seen_gray.gray !== want_gray.gray) begin
               $error("gray: expected %0d, actual %0d", want_gray.gray, seen_gray.gray);
               error_count++;
            end
            if (seen_gray.eof !== want_gray.eof) begin
               $error("end_of_frame: expected %0b, actual %0b", want_gray.eof, seen_gray.eof);
               error_count++;
            end
            if (seen_gray.clipped !== want_gray.clipped) begin
               $error("clipped: expected %0b, actual %0b",
                      want_gray.clipped, seen_gray.clipped);
               error_count++;
            end
         end
      end
   end

   initial begin
      int unsigned waited;
      range_low  = 0;
      range_high = 0;

      // Directed part. After reset the range is flat at zero.
      add_sample(CMD_CONVERT, 0, 1'b0, 1'b0);
      add_sample(CMD_CONVERT, 65535, 1'b1, 1'b1);
      // Measure without a first mark only widens the range; last is ignored here.
      add_sample(CMD_MEASURE, 1000, 1'b0, 1'b1);
      add_sample(CMD_CONVERT, 500, 1'b0, 1'b1);
      // Flat range: equal sample is black, neighbors clip.
      add_sample(CMD_MEASURE, 40000, 1'b1, 1'b0);
      add_sample(CMD_MEASURE, 40000, 1'b0, 1'b1);
      add_sample(CMD_CONVERT, 40000, 1'b0, 1'b0);
      add_sample(CMD_CONVERT, 39999, 1'b0, 1'b0);
      add_sample(CMD_CONVERT, 40001, 1'b0, 1'b1);
      // Full 16-bit range, including truncation near mid scale.
      add_sample(CMD_MEASURE, 0, 1'b1, 1'b0);
      add_sample(CMD_MEASURE, 65535, 1'b0, 1'b1);
      add_sample(CMD_CONVERT, 0, 1'b0, 1'b0);
      add_sample(CMD_CONVERT, 65535, 1'b0, 1'b0);
      add_sample(CMD_CONVERT, 32768, 1'b0, 1'b0);
      add_sample(CMD_CONVERT, 257, 1'b0, 1'b1);
      // Range of one code, with samples just below and just above.
      add_sample(CMD_MEASURE, 100, 1'b1, 1'b0);
      add_sample(CMD_MEASURE, 101, 1'b0, 1'b1);
      add_sample(CMD_CONVERT, 100, 1'b0, 1'b0);
      add_sample(CMD_CONVERT, 101, 1'b0, 1'b0);
      add_sample(CMD_CONVERT, 99, 1'b0, 1'b0);
      add_sample(CMD_CONVERT, 102, 1'b0, 1'b1);
      // Alternating bit patterns; first is ignored on a convert sample.
      add_sample(CMD_MEASURE, 16'hAAAA, 1'b1, 1'b1);
      add_sample(CMD_MEASURE, 16'h5555, 1'b0, 1'b0);
      add_sample(CMD_CONVERT, 16'hFFFF, 1'b1, 1'b1);

      while (pending_samples.size() < 24 + RANDOM_ITEMS) add_random_frame();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Sampled between edges so the driver's updates for this edge are settled.
      while (pending_samples.size() != 0 || req_tvalid) @(negedge clock);
      waited = 0;
      while (gray_expected.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (gray_expected.size() != 0) begin
         $error("%0d gray beats never arrived", gray_expected.size());
      end
      if (error_count == 0 && gray_expected.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
